### sv/gate_bytecode_stream_decoder_assert.svh
// Assertion macros for the gate bytecode stream decoder checkers
`ifndef GATE_BYTECODE_STREAM_DECODER_ASSERT_SVH
`define GATE_BYTECODE_STREAM_DECODER_ASSERT_SVH

// plain property on clk_i, off while rst_ni is low
`define GBSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define GBSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gbsd_pkg.sv
// Shared constants, codes and record types of the gate bytecode stream decoder
`timescale 1ns / 1ps
`default_nettype none
package gbsd_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 64;
  localparam int IDX_W   = 8;
  localparam int BCNT_W  = 3;

  // field lengths in bytes
  localparam int OPCODE_BYTES = 1;
  localparam int GATE_BYTES   = 1;
  localparam int PARAM_BYTES  = 8;
  localparam int QUBIT_BYTES  = 4;

  localparam logic [BCNT_W-1:0] OPC_LAST   = BCNT_W'(OPCODE_BYTES - 1);
  localparam logic [BCNT_W-1:0] GATE_LAST  = BCNT_W'(GATE_BYTES - 1);
  localparam logic [BCNT_W-1:0] PARAM_LAST = BCNT_W'(PARAM_BYTES - 1);
  localparam logic [BCNT_W-1:0] QUBIT_LAST = BCNT_W'(QUBIT_BYTES - 1);

  localparam logic [VALUE_W-1:0] MAX_OPCODE = VALUE_W'(2);

  localparam logic [BYTE_W-1:0] TYPE_NOP  = 8'd0;
  localparam logic [BYTE_W-1:0] TYPE_PRIM = 8'd1;
  localparam logic [BYTE_W-1:0] TYPE_GATE = 8'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  typedef enum logic [2:0] {
    KIND_OPCODE = 3'd0,
    KIND_GATE   = 3'd1,
    KIND_PCOUNT = 3'd2,
    KIND_PARAM  = 3'd3,
    KIND_TCOUNT = 3'd4,
    KIND_QUBIT  = 3'd5,
    KIND_ERROR  = 3'd6
  } rec_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXP_END  = 2'd1,
    ERR_BAD_OPCODE = 2'd2,
    ERR_BAD_TYPE   = 2'd3
  } err_code_e;

  typedef struct packed {
    rec_kind_e          kind;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   idx;
    err_code_e          err;
    logic               done;
  } rec_t;

  // one queue entry: record of the byte, plus a trailing unexpected-end error
  typedef struct packed {
    logic rec_vld;
    rec_t rec;
    logic end_err;
  } cmd_t;

endpackage
`default_nettype wire

### sv/gbsd_if.sv
// Valid/ready channel interfaces for byte input and record output
`timescale 1ns / 1ps
`default_nettype none
interface gbsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [gbsd_pkg::BYTE_W-1:0] byte_value;
  logic                        stream_last;

  modport source (output valid, output byte_value, output stream_last, input ready);
  modport sink   (input valid, input byte_value, input stream_last, output ready);
endinterface

interface gbsd_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   record_kind;
  logic [gbsd_pkg::VALUE_W-1:0] field_value;
  logic [gbsd_pkg::IDX_W-1:0]   item_index;
  logic [1:0]                   error_code;
  logic                         instr_done;

  modport source (output valid, output record_kind, output field_value, output item_index,
                  output error_code, output instr_done, input ready);
  modport sink   (input valid, input record_kind, input field_value, input item_index,
                  input error_code, input instr_done, output ready);
endinterface
`default_nettype wire

### sv/gbsd_fifo.sv
// Short command queue between the decode front and the record back end
`timescale 1ns / 1ps
`default_nettype none
module gbsd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  gbsd_pkg::cmd_t      data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output gbsd_pkg::cmd_t      data_o
);

  gbsd_pkg::cmd_t                  mem_q [gbsd_pkg::FIFO_DEPTH];
  logic [gbsd_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [gbsd_pkg::FIFO_PTR_W:0]   count_q;

  assign full_o  = (count_q == (gbsd_pkg::FIFO_PTR_W+1)'(gbsd_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/gbsd_front.sv
// Decode front: takes stream bytes, assembles fields and queues records
`timescale 1ns / 1ps
`default_nettype none
module gbsd_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  gbsd_in_if.sink        in_i,
  input  wire logic      full_i,
  output logic           push_o,
  output gbsd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPC,
    ST_GATE,
    ST_PCNT,
    ST_PARAM,
    ST_TCNT,
    ST_QUBIT
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [gbsd_pkg::BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic [gbsd_pkg::VALUE_W-1:0] acc_q, acc_d;
  logic [gbsd_pkg::IDX_W-1:0]   rem_q, rem_d;
  logic [gbsd_pkg::IDX_W-1:0]   pos_q, pos_d;
  logic                         std_q, std_d;
  logic                         disc_q, disc_d;

  logic                         accept;
  logic [gbsd_pkg::BYTE_W-1:0]  b;
  logic                         last;
  logic [gbsd_pkg::VALUE_W-1:0] ins;
  logic [gbsd_pkg::BCNT_W-1:0]  len_last;
  logic                         full;
  logic [gbsd_pkg::IDX_W-1:0]   rem_dec;
  logic                         early;
  gbsd_pkg::cmd_t               cmd;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.byte_value;
  assign last       = in_i.stream_last;
  assign rem_dec    = rem_q - 1'b1;

  // little-endian byte insertion into the field being built
  always_comb begin
    ins = acc_q;
    ins[{bcnt_q, 3'b000} +: gbsd_pkg::BYTE_W] = b;
  end

  always_comb begin
    case (phase_q)
      ST_OPC:   len_last = gbsd_pkg::OPC_LAST;
      ST_GATE:  len_last = gbsd_pkg::GATE_LAST;
      ST_PARAM: len_last = gbsd_pkg::PARAM_LAST;
      ST_QUBIT: len_last = gbsd_pkg::QUBIT_LAST;
      default:  len_last = '0;
    endcase
  end

  assign full = (bcnt_q == len_last);

  always_comb begin
    phase_d = phase_q;
    bcnt_d  = bcnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    std_d   = std_q;
    disc_d  = disc_q;
    early   = 1'b0;
    cmd     = '0;

    if (phase_q == ST_OPC || phase_q == ST_GATE || phase_q == ST_PARAM ||
        phase_q == ST_QUBIT) begin
      if (full) begin
        acc_d  = '0;
        bcnt_d = '0;
      end else begin
        acc_d  = ins;
        bcnt_d = bcnt_q + 1'b1;
      end
    end

    if (disc_q) begin
      early  = 1'b1;
      acc_d  = acc_q;
      bcnt_d = bcnt_q;
      if (last) begin
        disc_d = 1'b0;
      end
    end else begin
      case (phase_q)
        ST_IDLE: begin
          acc_d  = '0;
          bcnt_d = '0;
          rem_d  = '0;
          pos_d  = '0;
          if (b == gbsd_pkg::TYPE_PRIM) begin
            std_d   = 1'b0;
            phase_d = ST_OPC;
          end else if (b == gbsd_pkg::TYPE_GATE) begin
            std_d   = 1'b1;
            phase_d = ST_GATE;
          end else if (b != gbsd_pkg::TYPE_NOP) begin
            cmd.rec_vld  = 1'b1;
            cmd.rec.kind = gbsd_pkg::KIND_ERROR;
            cmd.rec.err  = gbsd_pkg::ERR_BAD_TYPE;
            cmd.rec.done = 1'b1;
            disc_d       = !last;
            early        = 1'b1;
          end
        end
        ST_OPC: begin
          if (full) begin
            if (ins > gbsd_pkg::MAX_OPCODE) begin
              cmd.rec_vld  = 1'b1;
              cmd.rec.kind = gbsd_pkg::KIND_ERROR;
              cmd.rec.err  = gbsd_pkg::ERR_BAD_OPCODE;
              cmd.rec.done = 1'b1;
              rem_d        = '0;
              pos_d        = '0;
              phase_d      = ST_IDLE;
              disc_d       = !last;
              early        = 1'b1;
            end else begin
              cmd.rec_vld   = 1'b1;
              cmd.rec.kind  = gbsd_pkg::KIND_OPCODE;
              cmd.rec.value = ins;
              phase_d       = ST_PCNT;
            end
          end
        end
        ST_GATE: begin
          if (full) begin
            cmd.rec_vld   = 1'b1;
            cmd.rec.kind  = gbsd_pkg::KIND_GATE;
            cmd.rec.value = ins;
            phase_d       = ST_PCNT;
          end
        end
        ST_PCNT: begin
          rem_d         = b;
          pos_d         = '0;
          cmd.rec_vld   = 1'b1;
          cmd.rec.kind  = gbsd_pkg::KIND_PCOUNT;
          cmd.rec.value = gbsd_pkg::VALUE_W'(b);
          cmd.rec.done  = (b == '0) && !std_q;
          if (b != '0) begin
            phase_d = ST_PARAM;
          end else begin
            phase_d = std_q ? ST_TCNT : ST_IDLE;
          end
        end
        ST_PARAM: begin
          if (full) begin
            rem_d         = rem_dec;
            pos_d         = pos_q + 1'b1;
            cmd.rec_vld   = 1'b1;
            cmd.rec.kind  = gbsd_pkg::KIND_PARAM;
            cmd.rec.value = ins;
            cmd.rec.idx   = pos_q;
            cmd.rec.done  = (rem_dec == '0) && !std_q;
            if (rem_dec == '0) begin
              phase_d = std_q ? ST_TCNT : ST_IDLE;
            end
          end
        end
        ST_TCNT: begin
          rem_d         = b;
          pos_d         = '0;
          cmd.rec_vld   = 1'b1;
          cmd.rec.kind  = gbsd_pkg::KIND_TCOUNT;
          cmd.rec.value = gbsd_pkg::VALUE_W'(b);
          cmd.rec.done  = (b == '0);
          phase_d       = (b == '0) ? ST_IDLE : ST_QUBIT;
        end
        ST_QUBIT: begin
          if (full) begin
            rem_d         = rem_dec;
            pos_d         = pos_q + 1'b1;
            cmd.rec_vld   = 1'b1;
            cmd.rec.kind  = gbsd_pkg::KIND_QUBIT;
            cmd.rec.value = ins;
            cmd.rec.idx   = pos_q;
            cmd.rec.done  = (rem_dec == '0);
            if (rem_dec == '0) begin
              phase_d = ST_IDLE;
            end
          end
        end
        default: begin
          acc_d   = '0;
          bcnt_d  = '0;
          rem_d   = '0;
          pos_d   = '0;
          phase_d = ST_IDLE;
        end
      endcase
    end

    // stream ended inside an instruction
    if (!early && last && phase_d != ST_IDLE) begin
      cmd.end_err = 1'b1;
      acc_d       = '0;
      bcnt_d      = '0;
      rem_d       = '0;
      pos_d       = '0;
      phase_d     = ST_IDLE;
    end
  end

  assign push_o = accept && (cmd.rec_vld || cmd.end_err);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ST_IDLE;
      bcnt_q  <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
      std_q   <= 1'b0;
      disc_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      bcnt_q  <= bcnt_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      std_q   <= std_d;
      disc_q  <= disc_d;
    end
  end

endmodule
`default_nettype wire

### sv/gbsd_back.sv
// Record back end: expands queued commands into output beats via a register
`timescale 1ns / 1ps
`default_nettype none
module gbsd_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  gbsd_pkg::cmd_t cmd_i,
  input  wire logic      empty_i,
  output logic           pop_o,
  gbsd_out_if.source     out_o
);

  logic           out_vld_q, out_vld_d;
  logic           second_q, second_d;
  gbsd_pkg::rec_t rec_q, rec_d;
  gbsd_pkg::rec_t end_rec;
  logic           load;
  logic           use_err;

  always_comb begin
    end_rec      = '0;
    end_rec.kind = gbsd_pkg::KIND_ERROR;
    end_rec.err  = gbsd_pkg::ERR_UNEXP_END;
    end_rec.done = 1'b1;
  end

  assign load    = !empty_i && (!out_vld_q || out_o.ready);
  assign use_err = second_q || !cmd_i.rec_vld;

  always_comb begin
    pop_o     = 1'b0;
    second_d  = second_q;
    rec_d     = rec_q;
    out_vld_d = out_vld_q && !out_o.ready;
    if (load) begin
      out_vld_d = 1'b1;
      if (use_err) begin
        rec_d    = end_rec;
        pop_o    = 1'b1;
        second_d = 1'b0;
      end else begin
        rec_d    = cmd_i.rec;
        pop_o    = !cmd_i.end_err;
        second_d = cmd_i.end_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      second_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      second_q  <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.record_kind = rec_q.kind;
  assign out_o.field_value = rec_q.value;
  assign out_o.item_index  = rec_q.idx;
  assign out_o.error_code  = rec_q.err;
  assign out_o.instr_done  = rec_q.done;

endmodule
`default_nettype wire

### sv/gate_bytecode_stream_decoder.sv
// A record of an accepted byte passes through the command queue and then the output register.
// Throughput: one byte per cycle while the queue has room; state updates per byte taken.
// A last byte mid-instruction yields its record, if any, then an unexpected-end error.
// A 4-entry command queue parts the decode front from the output register.
// Reset (rst_ni low, asynchronous): decoder idle awaiting a type byte, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module gate_bytecode_stream_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gbsd_in_if.sink    in_i,
  gbsd_out_if.source out_o
);

  gbsd_pkg::cmd_t push_cmd;
  gbsd_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  gbsd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  gbsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_cmd)
  );

  gbsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

### sv/gbsd_checker.sv
// Port-level checks on the record output of the decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "gate_bytecode_stream_decoder_assert.svh"
module gbsd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [2:0]                   record_kind_i,
  input wire logic [gbsd_pkg::VALUE_W-1:0] field_value_i,
  input wire logic [gbsd_pkg::IDX_W-1:0]   item_index_i,
  input wire logic [1:0]                   error_code_i,
  input wire logic                         instr_done_i
);

  logic is_err;
  logic no_index;

  assign is_err   = (record_kind_i == gbsd_pkg::KIND_ERROR);
  assign no_index = (record_kind_i == gbsd_pkg::KIND_OPCODE) ||
                    (record_kind_i == gbsd_pkg::KIND_GATE) ||
                    (record_kind_i == gbsd_pkg::KIND_PCOUNT) ||
                    (record_kind_i == gbsd_pkg::KIND_TCOUNT) || is_err;

  `GBSD_ASSERT_NEXT(a_beat_held, out_valid_i && !out_ready_i, out_valid_i && $stable(record_kind_i) && $stable(field_value_i) && $stable(item_index_i) && $stable(instr_done_i), "stalled beat changed")
  `GBSD_ASSERT_IMPL(a_err_rec, out_valid_i && is_err, field_value_i == '0 && instr_done_i && error_code_i != gbsd_pkg::ERR_NONE, "malformed error record")
  `GBSD_ASSERT_IMPL(a_no_err_code, out_valid_i && !is_err, error_code_i == gbsd_pkg::ERR_NONE, "error code on data record")
  `GBSD_ASSERT(a_index_zero, !(out_valid_i && no_index && item_index_i != '0), "index on non-list record")

endmodule

bind gate_bytecode_stream_decoder gbsd_checker u_gbsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .record_kind_i (out_o.record_kind),
  .field_value_i (out_o.field_value),
  .item_index_i  (out_o.item_index),
  .error_code_i  (out_o.error_code),
  .instr_done_i  (out_o.instr_done)
);
`default_nettype wire
